[rtl/tsc_pkg.sv]
// Shared constants for the Taylor-series sine/cosine evaluator.
`timescale 1ns / 1ps

package tsc_pkg;

  // Fixed-point format and series limit.
  localparam int FRAC_BITS = 28;
  localparam int MAX_TERMS = 32;

  // Port field widths.
  localparam int ANGLE_W = 31;
  localparam int VALUE_W = 30;
  localparam int COUNT_W = 6;

  // Datapath widths; the series terms stay below about 11.0 for angles within 4.0.
  localparam int XMAG_W = 31;
  localparam int XX_W   = 33;
  localparam int TERM_W = 36;
  localparam int NUM_W  = 37;
  localparam int QUO_W  = 35;
  localparam int SUM_W  = 38;

  // Denominator tables and reciprocal scaling. The numerator stays below 2^36,
  // so a reciprocal scaled by 2^36 leaves the quotient estimate at most one low.
  localparam int DEN_W     = 13;
  localparam int RCP_W     = 36;
  localparam int RCP_SHIFT = 36;
  localparam int IDX_W     = $clog2(MAX_TERMS);

  // Shared multiply-accumulate unit.
  localparam int MUL_A_W = 37;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 72;

endpackage

[rtl/tsc_mac.sv]
// Shared multiply-accumulate unit: one 37x18 product per cycle into a 72-bit accumulator.
`timescale 1ns / 1ps

module tsc_mac
  import tsc_pkg::*;
(
  input  logic               clk,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  input  logic [ACC_W-1:0]   rnd,
  input  logic               hi,
  output logic [ACC_W-1:0]   sum_out,
  output logic [ACC_W-1:0]   acc
);

  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  shifted;
  logic [ACC_W-1:0]  base;

  // The low half of B starts a new sum from the rounding constant; the high half
  // is weighted by 2^18 and added to the running accumulator.
  assign prod    = a * b;
  assign shifted = hi ? ACC_W'({prod, {MUL_B_W{1'b0}}}) : ACC_W'(prod);
  assign base    = hi ? acc : rnd;
  assign sum_out = base + shifted;

  // Accumulator register.
  always_ff @(posedge clk) begin
    acc <= sum_out;
  end

endmodule

[rtl/taylor_sine_cosine.sv]
// Top level of the Taylor-series sine/cosine evaluator.
`timescale 1ns / 1ps

// One angle (Q3.28 radians) and a function select enter per transfer, and one Q2.28
// result, clamped to plus or minus one, leaves per item. With n = min(term_count, 32),
// an item runs to its end before the block is ready again: the square of the angle, then
// n series terms on the single 37x18 multiply-accumulate unit, which needs two passes
// for each wide product (term times square, quotient estimate by reciprocal) and one
// for the remainder check of the rounded division. The finished result waits in an
// output register, so the next item is taken while it is unclaimed.
module taylor_sine_cosine
  import tsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // Configuration: term_count.
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  // Input stream.
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [31:0]        s_tdata,   // [30:0] angle, [31] zero
  input  logic               s_tuser,   // [0] cmd (0 sine, 1 cosine)
  // Output stream.
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [31:0]        m_tdata    // [29:0] value, [31:30] zero
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SQR  = 8'b0000_0010,
    S_TERM = 8'b0000_0100,
    S_RCP  = 8'b0000_1000,
    S_CHK  = 8'b0001_0000,
    S_FIX1 = 8'b0010_0000,
    S_FIX2 = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  localparam logic [ACC_W-1:0]          ROUND    = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic [TERM_W-1:0]         TERM_ONE = TERM_W'(1) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0]   SUM_ONE  = SUM_W'(1) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0]   SUM_MONE = -SUM_ONE;
  localparam logic signed [VALUE_W-1:0] VAL_ONE  = VALUE_W'(1) << FRAC_BITS;
  localparam logic signed [VALUE_W-1:0] VAL_MONE = -VAL_ONE;

  state_t              state;
  logic                ph;
  logic [COUNT_W-1:0]  i;
  logic [COUNT_W-1:0]  term_count;
  logic [COUNT_W-1:0]  n_cap;
  logic                out_free;

  logic                cos_r;
  logic [XMAG_W-1:0]   x_mag;
  logic [XMAG_W-1:0]   x_mag_in;
  logic [XX_W-1:0]     xx;
  logic [TERM_W-1:0]   term_mag;
  logic                term_neg;
  logic signed [SUM_W-1:0] sum;
  logic [NUM_W-1:0]    num;
  logic [QUO_W-1:0]    quo;
  logic                bump;
  logic [VALUE_W-1:0]  clamped;

  logic [DEN_W-1:0]    den_sin [MAX_TERMS];
  logic [DEN_W-1:0]    den_cos [MAX_TERMS];
  logic [RCP_W-1:0]    rcp_sin [MAX_TERMS];
  logic [RCP_W-1:0]    rcp_cos [MAX_TERMS];
  logic [IDX_W-1:0]    tab_idx;
  logic [DEN_W-1:0]    den_r;
  logic [RCP_W-1:0]    rcp_r;

  logic [MUL_A_W-1:0]  mac_a;
  logic [MUL_B_W-1:0]  mac_b;
  logic [ACC_W-1:0]    mac_rnd;
  logic                mac_hi;
  logic [ACC_W-1:0]    acc_sum;
  logic [ACC_W-1:0]    acc;

  // Denominators 2i(2i+1) and 2i(2i-1) with their reciprocals floor(2^36 / den).
  for (genvar g = 0; g < MAX_TERMS; g++) begin : g_tab
    localparam longint unsigned DS = 64'(2 * (g + 1) * (2 * (g + 1) + 1));
    localparam longint unsigned DC = 64'(2 * (g + 1) * (2 * (g + 1) - 1));
    localparam longint unsigned RS = (64'd1 << RCP_SHIFT) / DS;
    localparam longint unsigned RC = (64'd1 << RCP_SHIFT) / DC;
    assign den_sin[g] = DEN_W'(DS);
    assign den_cos[g] = DEN_W'(DC);
    assign rcp_sin[g] = RCP_W'(RS);
    assign rcp_cos[g] = RCP_W'(RC);
  end

  tsc_mac u_mac (
    .clk     (clk),
    .a       (mac_a),
    .b       (mac_b),
    .rnd     (mac_rnd),
    .hi      (mac_hi),
    .sum_out (acc_sum),
    .acc     (acc)
  );

  // Handshake and small helpers.
  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign n_cap    = (term_count > COUNT_W'(MAX_TERMS)) ? COUNT_W'(MAX_TERMS) : term_count;
  assign x_mag_in = s_tdata[ANGLE_W-1] ? (~s_tdata[ANGLE_W-1:0] + XMAG_W'(1))
                                       : s_tdata[ANGLE_W-1:0];
  assign tab_idx  = (state == S_FIX2) ? i[IDX_W-1:0] : '0;
  assign bump     = ({1'b0, num} >= acc[NUM_W:0]);

  // Final clamp to plus or minus one.
  always_comb begin
    if (sum > SUM_ONE) begin
      clamped = VAL_ONE;
    end else if (sum < SUM_MONE) begin
      clamped = VAL_MONE;
    end else begin
      clamped = sum[VALUE_W-1:0];
    end
  end

  // Operand selection for the shared unit.
  always_comb begin
    mac_a   = '0;
    mac_b   = '0;
    mac_rnd = '0;
    mac_hi  = ph;
    case (state)
      S_SQR: begin
        mac_a   = MUL_A_W'(x_mag);
        mac_b   = ph ? MUL_B_W'(x_mag[XMAG_W-1:MUL_B_W]) : x_mag[MUL_B_W-1:0];
        mac_rnd = ROUND;
      end
      S_TERM: begin
        // Rounding of the product and half the denominator are folded in here.
        mac_a   = MUL_A_W'(term_mag);
        mac_b   = ph ? MUL_B_W'(xx[XX_W-1:MUL_B_W]) : xx[MUL_B_W-1:0];
        mac_rnd = ROUND | (ACC_W'(den_r[DEN_W-1:1]) << FRAC_BITS);
      end
      S_RCP: begin
        mac_a = num;
        mac_b = ph ? MUL_B_W'(rcp_r[RCP_W-1:MUL_B_W]) : rcp_r[MUL_B_W-1:0];
      end
      S_CHK: begin
        // (q0 + 1) * den, compared against the numerator in the next cycle.
        mac_a   = MUL_A_W'(quo);
        mac_b   = MUL_B_W'(den_r);
        mac_rnd = ACC_W'(den_r);
        mac_hi  = 1'b0;
      end
      default: begin
        mac_hi = 1'b0;
      end
    endcase
  end

  // Sequencer, configuration register and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ph         <= 1'b0;
      i          <= '0;
      term_count <= COUNT_W'(10);
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        term_count <= cfg_wdata;
      end
      // A result taken in the done state is replaced there by the new one.
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_SQR;
            ph    <= 1'b0;
          end
        end
        S_SQR: begin
          ph <= !ph;
          if (ph) begin
            i     <= COUNT_W'(1);
            state <= (n_cap == '0) ? S_DONE : S_TERM;
          end
        end
        S_TERM: begin
          ph <= !ph;
          if (ph) begin
            state <= S_RCP;
          end
        end
        S_RCP: begin
          ph <= !ph;
          if (ph) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          state <= S_FIX1;
        end
        S_FIX1: begin
          state <= S_FIX2;
        end
        S_FIX2: begin
          if (i == n_cap) begin
            state <= S_DONE;
          end else begin
            i     <= i + COUNT_W'(1);
            state <= S_TERM;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    // Input transfer: first term and running sum.
    if (state == S_IDLE && s_tvalid) begin
      cos_r    <= s_tuser;
      x_mag    <= x_mag_in;
      term_mag <= s_tuser ? TERM_ONE : TERM_W'(x_mag_in);
      term_neg <= s_tuser ? 1'b0 : s_tdata[ANGLE_W-1];
      sum      <= s_tuser ? SUM_ONE
                          : {{(SUM_W-ANGLE_W){s_tdata[ANGLE_W-1]}}, s_tdata[ANGLE_W-1:0]};
    end
    // Denominator and reciprocal for the coming round.
    if ((state == S_SQR && ph) || state == S_FIX2) begin
      den_r <= cos_r ? den_cos[tab_idx] : den_sin[tab_idx];
      rcp_r <= cos_r ? rcp_cos[tab_idx] : rcp_sin[tab_idx];
    end
    if (state == S_SQR && ph) begin
      xx <= acc_sum[FRAC_BITS+XX_W-1:FRAC_BITS];
    end
    // Rounded product plus half the denominator.
    if (state == S_TERM && ph) begin
      num <= acc_sum[FRAC_BITS+NUM_W-1:FRAC_BITS];
    end
    // Quotient estimate, then the one-step correction.
    if (state == S_RCP && ph) begin
      quo <= acc_sum[RCP_SHIFT+QUO_W-1:RCP_SHIFT];
    end
    if (state == S_FIX1) begin
      quo <= quo + QUO_W'(bump);
    end
    // The new term has the opposite sign of the previous one.
    if (state == S_FIX2) begin
      term_mag <= TERM_W'(quo);
      term_neg <= !term_neg;
      sum      <= term_neg ? (sum + SUM_W'(quo)) : (sum - SUM_W'(quo));
    end
    if (state == S_DONE && out_free) begin
      m_tdata <= {{(32-VALUE_W){1'b0}}, clamped};
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_SQR && !ph))
    else $error("input transfer did not start the square step");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && m_tvalid && !m_tready) |=> (state == S_DONE))
    else $error("result left the done state while the output register was full");

  a_value_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[VALUE_W-1:0]) <= VAL_ONE &&
                  $signed(m_tdata[VALUE_W-1:0]) >= VAL_MONE))
    else $error("result outside plus or minus one");
`endif

endmodule

[tb/tb_taylor_sine_cosine.sv]
// Self-checking testbench for the Taylor-series sine/cosine evaluator.
`timescale 1ns / 1ps

module tb_taylor_sine_cosine;
  import tsc_pkg::*;

  // Function select codes carried in tuser.
  localparam logic CMD_SINE   = 1'b0;
  localparam logic CMD_COSINE = 1'b1;

  // Frequently used Q3.28 angles and Q2.28 values.
  localparam logic [ANGLE_W-1:0] PI_Q      = 31'd843314857;
  localparam logic [ANGLE_W-1:0] HALF_PI_Q = 31'd421657428;
  localparam logic [ANGLE_W-1:0] ONE_A     = 31'd268435456;
  localparam logic [ANGLE_W-1:0] HALF_A    = 31'd134217728;
  localparam logic [ANGLE_W-1:0] ANG_MAX   = 31'h3FFF_FFFF;
  localparam logic [ANGLE_W-1:0] ANG_MIN   = 31'h4000_0000;
  localparam logic [VALUE_W-1:0] ONE_V     = 30'd268435456;
  localparam logic [VALUE_W-1:0] HALF_V    = 30'd134217728;

  localparam logic [63:0] SUM_LIMIT    = 64'd1 << 62;
  localparam int          RESET_COUNT  = 10;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          DRAIN_CYCLES = 7 * MAX_TERMS + 16;
  localparam int          RX_HOLD_CYCLES = 300;
  localparam int          PHASES       = 12;
  localparam int          PHASE_ITEMS  = 120;
  localparam int          MAX_REPORTS  = 100;

  // One row of the directed stimulus table.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               cmd;
    logic [ANGLE_W-1:0] angle;
    logic               known;
    logic [VALUE_W-1:0] value;
  } sincos_row_t;

  // One awaited result together with the item that caused it.
  typedef struct packed {
    logic               cmd;
    logic [ANGLE_W-1:0] angle;
    logic [VALUE_W-1:0] value;
  } sincos_check_t;

  localparam int DIR_ROWS = 23;
  localparam sincos_row_t DIRECTED [0:DIR_ROWS-1] = '{
    '{6'd10, CMD_SINE,   31'd0,      1'b1, 30'd0},
    '{6'd10, CMD_COSINE, 31'd0,      1'b1, ONE_V},
    '{6'd10, CMD_SINE,   PI_Q,       1'b0, 30'd0},
    '{6'd10, CMD_SINE,   -PI_Q,      1'b0, 30'd0},
    '{6'd10, CMD_COSINE, PI_Q,       1'b0, 30'd0},
    '{6'd10, CMD_COSINE, -PI_Q,      1'b0, 30'd0},
    '{6'd10, CMD_SINE,   ANG_MAX,    1'b0, 30'd0},
    '{6'd10, CMD_COSINE, ANG_MIN,    1'b0, 30'd0},
    '{6'd10, CMD_SINE,   ONE_A,      1'b0, 30'd0},
    '{6'd10, CMD_COSINE, -HALF_PI_Q, 1'b0, 30'd0},
    // With no added terms the first term comes out, clamped to plus or minus one.
    '{6'd0,  CMD_SINE,   HALF_A,     1'b1, HALF_V},
    '{6'd0,  CMD_SINE,   ANG_MAX,    1'b1, ONE_V},
    '{6'd0,  CMD_SINE,   ANG_MIN,    1'b1, -ONE_V},
    '{6'd0,  CMD_COSINE, PI_Q,       1'b1, ONE_V},
    // Counts above the series limit are capped.
    '{6'd63, CMD_SINE,   PI_Q,       1'b0, 30'd0},
    '{6'd63, CMD_COSINE, ANG_MIN,    1'b0, 30'd0},
    '{6'd63, CMD_COSINE, 31'd0,      1'b1, ONE_V},
    '{6'd32, CMD_COSINE, ANG_MAX,    1'b0, 30'd0},
    '{6'd32, CMD_SINE,   -HALF_PI_Q, 1'b0, 30'd0},
    '{6'd1,  CMD_SINE,   ONE_A,      1'b0, 30'd0},
    '{6'd1,  CMD_COSINE, -ONE_A,     1'b0, 30'd0},
    '{6'd1,  CMD_SINE,   31'd1,      1'b0, 30'd0},
    '{6'd10, CMD_COSINE, -31'd1,     1'b0, 30'd0}
  };

  // Term counts of the random phases, the extremes among them.
  localparam logic [COUNT_W-1:0] PHASE_COUNT [0:PHASES-1] = '{
    6'd10, 6'd1, 6'd63, 6'd4, 6'd0, 6'd32, 6'd2, 6'd7, 6'd63, 6'd15, 6'd3, 6'd10
  };

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;
  logic               s_tvalid;
  logic               s_tready;
  logic [31:0]        s_tdata;   // [30:0] angle, [31] zero
  logic               s_tuser;   // [0] cmd
  logic               m_tvalid;
  logic               m_tready;
  logic [31:0]        m_tdata;   // [29:0] value, [31:30] zero

  sincos_check_t      awaited_values [$];
  sincos_check_t      head_value;
  logic [COUNT_W-1:0] active_count;
  int                 error_count;
  int                 src_idle_pct;
  int                 dst_idle_pct;
  bit                 hold_request;
  int                 hold_left;
  int                 phase;
  int                 row;
  int                 k;

  taylor_sine_cosine u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // Rounded magnitude of a*b scaled down by 2^FRAC_BITS, saturated at 2^62.
  function automatic logic [63:0] round_product_mag(input logic [63:0] a,
                                                    input logic [63:0] b);
    logic [127:0] full;
    full = {64'd0, a} * {64'd0, b} + (128'd1 << (FRAC_BITS - 1));
    if (full[127:64+FRAC_BITS] != '0) return SUM_LIMIT;
    if (full[63+FRAC_BITS:FRAC_BITS] > SUM_LIMIT) return SUM_LIMIT;
    return full[63+FRAC_BITS:FRAC_BITS];
  endfunction

  function automatic logic [63:0] abs64(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint fixed_mul(input longint a, input longint b);
    logic [63:0] m;
    m = round_product_mag(abs64(a), abs64(b));
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  // Division by a small positive integer, rounding ties away from zero.
  function automatic longint fixed_div(input longint a, input logic [63:0] den);
    logic [63:0] m;
    m = (abs64(a) + (den >> 1)) / den;
    return (a < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint sat_sum(input longint a, input longint b);
    longint s;
    s = a + b;
    if (s > longint'(SUM_LIMIT)) s = longint'(SUM_LIMIT);
    if (s < -longint'(SUM_LIMIT)) s = -longint'(SUM_LIMIT);
    return s;
  endfunction

  // Series sum for one angle at the given term count, clamped to plus or minus one.
  function automatic logic [VALUE_W-1:0] taylor_value(input logic cmd,
                                                      input logic [ANGLE_W-1:0] angle,
                                                      input logic [COUNT_W-1:0] count);
    longint      x;
    longint      xx;
    longint      term;
    longint      sum;
    longint      one;
    int          n;
    int          i;
    logic [63:0] den;
    x    = longint'(signed'(angle));
    one  = longint'(1) << FRAC_BITS;
    n    = (count > MAX_TERMS) ? MAX_TERMS : int'(count);
    xx   = fixed_mul(x, x);
    term = (cmd == CMD_COSINE) ? one : x;
    sum  = term;
    for (i = 1; i <= n; i++) begin
      den  = (cmd == CMD_COSINE) ? 64'(2 * i * (2 * i - 1)) : 64'(2 * i * (2 * i + 1));
      term = -fixed_div(fixed_mul(term, xx), den);
      sum  = sat_sum(sum, term);
    end
    if (sum > one) sum = one;
    if (sum < -one) sum = -one;
    return VALUE_W'(sum);
  endfunction

  // Mostly angles within plus or minus pi, some over the whole field, some corners.
  function automatic logic [ANGLE_W-1:0] pick_angle();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 75) return ANGLE_W'($urandom_range(2 * 843314857)) - PI_Q;
    if (sel < 88) return ANGLE_W'($urandom());
    case ($urandom_range(9))
      0: return '0;
      1: return PI_Q;
      2: return -PI_Q;
      3: return ANG_MAX;
      4: return ANG_MIN;
      5: return ONE_A;
      6: return -ONE_A;
      7: return 31'd1;
      8: return -31'd1;
      default: return HALF_PI_Q;
    endcase
  endfunction

  // Offers one item after a random gap and records its result once it transfers.
  task automatic send_item(input logic cmd, input logic [ANGLE_W-1:0] angle,
                           input logic known, input logic [VALUE_W-1:0] value);
    sincos_check_t item;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(32 - ANGLE_W){1'b0}}, angle};
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    item.cmd   = cmd;
    item.angle = angle;
    item.value = known ? value : taylor_value(cmd, angle, active_count);
    awaited_values.push_back(item);
    @(negedge clk);
  endtask

  // Writes the term count once every awaited result has been taken.
  task automatic write_term_count(input logic [COUNT_W-1:0] count);
    s_tvalid <= 1'b0;
    while (awaited_values.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(negedge clk);
    cfg_we       <= 1'b0;
    active_count = count;
  endtask

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver readiness, with an occasional long hold-off on request.
  initial begin
    m_tready  = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = RX_HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= dst_idle_pct);
      end
    end
  end

  // Compare each output transfer with the oldest awaited result.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_values.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
      end else begin
        head_value = awaited_values.pop_front();
        if (m_tdata !== {{(32 - VALUE_W){1'b0}}, head_value.value}) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: cmd %0d angle %h: expected %h, actual %h", $time,
                     head_value.cmd, head_value.angle,
                     {{(32 - VALUE_W){1'b0}}, head_value.value}, m_tdata);
        end
      end
    end
  end

  // Stimulus: reset, directed table, random phases, drain.
  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = 1'b0;
    error_count  = 0;
    hold_request = 1'b0;
    src_idle_pct = 34;
    dst_idle_pct = 59;
    active_count = COUNT_W'(RESET_COUNT);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (row = 0; row < DIR_ROWS; row++) begin
      if (DIRECTED[row].count != active_count) write_term_count(DIRECTED[row].count);
      send_item(DIRECTED[row].cmd, DIRECTED[row].angle,
                DIRECTED[row].known, DIRECTED[row].value);
    end

    // Idling pattern changes every third of the random part.
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase < PHASES / 3) begin
        src_idle_pct = 34;
        dst_idle_pct = 59;
      end else if (phase < 2 * PHASES / 3) begin
        src_idle_pct = 59;
        dst_idle_pct = 34;
      end else begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
      end
      write_term_count(PHASE_COUNT[phase]);
      if (phase == 1 || phase == 9) hold_request = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++)
        send_item(logic'($urandom_range(1)), pick_angle(), 1'b0, '0);
    end

    s_tvalid <= 1'b0;
    while (awaited_values.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[taylor_sine_cosine] OK");
    end else begin
      $display("[taylor_sine_cosine] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #20_000_000;
    $display("[taylor_sine_cosine] ERROR");
    $finish;
  end

endmodule
